// ===== hdl/fbpa_pkg.sv =====
// Shared types and constants of the fixed block pool allocator.
// Used by the controller, the datapath, the divider and the top level.
package fbpa_pkg;

    localparam int ADDR_W = 32;
    localparam int BS_W   = 16;
    localparam int POOL_W = 9;
    localparam int CNT_W  = $clog2(ADDR_W);

    // register indexes of the configuration port
    localparam logic [1:0] CFG_BASE = 2'd0;
    localparam logic [1:0] CFG_BS   = 2'd1;
    localparam logic [1:0] CFG_POOL = 2'd2;

    // request kinds carried on tuser
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [ADDR_W-1:0] RST_BASE = 32'd0;
    localparam logic [BS_W-1:0]   RST_BS   = 16'd64;
    localparam logic [POOL_W-1:0] RST_POOL = 9'd256;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_RANGE    = 3'd2,
        ST_ALIGN    = 3'd3,
        ST_NOTALLOC = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_A_READ,
        S_A_MUL,
        S_A_ADD,
        S_F_RANGE,
        S_F_DIV,
        S_F_BUSY,
        S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic    clr_step;   // clear one busy bit, reload counters
        logic    take_in;    // latch request
        logic    pop;        // read top of free stack
        logic    mark;       // set busy bit, form index * size
        logic    add_base;   // form block address
        logic    div_start;
        logic    busy_rd;
        logic    push_free;  // clear busy bit, push index
        logic    set_st;
        t_status st_code;
        logic    load_out;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic reinit;
        logic clr_last;
        logic empty;
        logic out_of_range;
        logic div_done;
        logic misaligned;
        logic block_busy;
        logic out_free;
    } t_dp_stat;

endpackage

// ===== hdl/fbpa_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on fbpa_pkg for widths.
module fbpa_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [fbpa_pkg::ADDR_W-1:0]   i_dividend,
    input  logic [fbpa_pkg::BS_W-1:0]     i_divisor,
    output logic                          o_done,
    output logic [fbpa_pkg::ADDR_W-1:0]   o_quot,
    output logic [fbpa_pkg::BS_W-1:0]     o_rem
);

    logic [fbpa_pkg::ADDR_W-1:0] r_quot;
    logic [fbpa_pkg::BS_W-1:0]   r_rem;
    logic [fbpa_pkg::BS_W-1:0]   r_div;
    logic [fbpa_pkg::CNT_W-1:0]  r_cnt;
    logic                        r_run;
    logic                        r_done;

    logic [fbpa_pkg::BS_W:0]     w_sh;
    logic [fbpa_pkg::BS_W:0]     w_diff;
    logic                        w_ge;

    assign w_sh   = {r_rem, r_quot[fbpa_pkg::ADDR_W-1]};
    assign w_ge   = (w_sh >= {1'b0, r_div});
    assign w_diff = w_sh - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == fbpa_pkg::CNT_W'(fbpa_pkg::ADDR_W - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_run) begin
            r_quot <= {r_quot[fbpa_pkg::ADDR_W-2:0], w_ge};
            r_rem  <= w_ge ? w_diff[fbpa_pkg::BS_W-1:0] : w_sh[fbpa_pkg::BS_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

// ===== hdl/fbpa_datapath.sv =====
// Datapath: configuration registers, free stack and busy-bit memories,
// counters, address arithmetic and result register. Uses fbpa_pkg, fbpa_div.
module fbpa_datapath #(
    parameter int NUM_BLOCKS = 256
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [1:0]                        i_cfg_index,
    input  logic [fbpa_pkg::ADDR_W-1:0]       i_cfg_data,
    input  logic [fbpa_pkg::ADDR_W-1:0]       i_addr,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic [fbpa_pkg::ADDR_W-1:0]       o_out_addr,
    output fbpa_pkg::t_status                 o_out_status,
    input  fbpa_pkg::t_dp_cmd                 i_cmd,
    output fbpa_pkg::t_dp_stat                o_stat
);

    localparam int IW = $clog2(NUM_BLOCKS);
    localparam int CW = $clog2(NUM_BLOCKS + 1);
    localparam int PW = (CW > fbpa_pkg::POOL_W) ? CW : fbpa_pkg::POOL_W;
    localparam int SW = CW + fbpa_pkg::BS_W;
    localparam int MW = (SW > fbpa_pkg::ADDR_W) ? SW : fbpa_pkg::ADDR_W;
    localparam int QW = IW + fbpa_pkg::BS_W;

    logic [fbpa_pkg::ADDR_W-1:0] r_base;
    logic [fbpa_pkg::BS_W-1:0]   r_block_size;
    logic [fbpa_pkg::POOL_W-1:0] r_pool_blocks;

    logic [SW-1:0]               r_span;
    logic [IW-1:0]               r_clr;
    logic [CW-1:0]               r_count;
    logic [CW-1:0]               r_low;     // lowest fill since init; below it entries are k
    logic [IW-1:0]               r_stk_mem [NUM_BLOCKS];
    logic                        r_busy_mem [NUM_BLOCKS];
    logic [IW-1:0]               r_stk_q;
    logic                        r_busy_q;
    logic                        r_ident;
    logic [IW-1:0]               r_pidx;
    logic [QW-1:0]               r_prod;
    logic [fbpa_pkg::ADDR_W-1:0] r_addr;
    logic [fbpa_pkg::ADDR_W-1:0] r_res_addr;
    fbpa_pkg::t_status           r_status;
    logic                        r_out_valid;
    logic [fbpa_pkg::ADDR_W-1:0] r_out_addr;
    fbpa_pkg::t_status           r_out_status;

    logic                        w_reinit;
    logic [PW-1:0]               w_pb_ext;
    logic [PW-1:0]               w_nb_ext;
    logic [CW-1:0]               w_n;
    logic [CW-1:0]               w_top;
    logic [IW-1:0]               w_aidx;
    logic [IW-1:0]               w_fidx;
    logic [fbpa_pkg::ADDR_W-1:0] w_off;
    logic [fbpa_pkg::ADDR_W-1:0] w_quot;
    logic [fbpa_pkg::BS_W-1:0]   w_rem;
    logic                        w_div_done;
    logic                        w_can_push;

    assign w_reinit = i_cfg_we && ((i_cfg_index == fbpa_pkg::CFG_BASE) ||
                                   (i_cfg_index == fbpa_pkg::CFG_BS) ||
                                   (i_cfg_index == fbpa_pkg::CFG_POOL));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base        <= fbpa_pkg::RST_BASE;
            r_block_size  <= fbpa_pkg::RST_BS;
            r_pool_blocks <= fbpa_pkg::RST_POOL;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                fbpa_pkg::CFG_BASE: r_base        <= i_cfg_data;
                fbpa_pkg::CFG_BS:   r_block_size  <= i_cfg_data[fbpa_pkg::BS_W-1:0];
                fbpa_pkg::CFG_POOL: r_pool_blocks <= i_cfg_data[fbpa_pkg::POOL_W-1:0];
                default: ;
            endcase
        end
    end

    // effective pool size, saturated to the built depth
    assign w_pb_ext = PW'(r_pool_blocks);
    assign w_nb_ext = PW'(NUM_BLOCKS);
    assign w_n      = (w_pb_ext > w_nb_ext) ? CW'(w_nb_ext) : CW'(w_pb_ext);

    always_ff @(posedge i_clk) begin
        r_span <= SW'(w_n) * SW'(r_block_size);
    end

    assign w_top      = r_count - 1'b1;
    assign w_aidx     = r_ident ? r_pidx : r_stk_q;
    assign w_fidx     = w_quot[IW-1:0];
    assign w_off      = r_addr - r_base;
    assign w_can_push = (r_count < CW'(NUM_BLOCKS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr   <= '0;
            r_count <= '0;
            r_low   <= '0;
        end else begin
            if (w_reinit) begin
                r_clr <= '0;
            end else if (i_cmd.clr_step) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cmd.clr_step) begin
                r_count <= w_n;
                r_low   <= w_n;
            end else if (i_cmd.pop) begin
                r_count <= w_top;
                if (r_count == r_low) begin
                    r_low <= w_top;
                end
            end else if (i_cmd.push_free && w_can_push) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    // free stack
    always_ff @(posedge i_clk) begin
        if (i_cmd.pop) begin
            r_stk_q <= r_stk_mem[w_top[IW-1:0]];
            r_ident <= (r_count == r_low);
            r_pidx  <= w_top[IW-1:0];
        end
        if (i_cmd.push_free && w_can_push) begin
            r_stk_mem[r_count[IW-1:0]] <= w_fidx;
        end
    end

    // busy bits
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            r_busy_mem[r_clr] <= 1'b0;
        end else if (i_cmd.mark) begin
            r_busy_mem[w_aidx] <= 1'b1;
        end else if (i_cmd.push_free) begin
            r_busy_mem[w_fidx] <= 1'b0;
        end
        if (i_cmd.busy_rd) begin
            r_busy_q <= r_busy_mem[w_fidx];
        end
    end

    fbpa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_off),
        .i_divisor  (r_block_size),
        .o_done     (w_div_done),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    // request and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_in) begin
            r_addr     <= i_addr;
            r_res_addr <= '0;
            r_status   <= fbpa_pkg::ST_OK;
        end else begin
            if (i_cmd.set_st) begin
                r_status <= i_cmd.st_code;
            end
            if (i_cmd.add_base) begin
                r_res_addr <= r_base + fbpa_pkg::ADDR_W'(r_prod);
            end
        end
        if (i_cmd.mark) begin
            r_prod <= QW'(w_aidx) * QW'(r_block_size);
        end
        if (i_cmd.load_out) begin
            r_out_addr   <= r_res_addr;
            r_out_status <= r_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_addr   = r_out_addr;
    assign o_out_status = r_out_status;

    always_comb begin
        o_stat.reinit       = w_reinit;
        o_stat.clr_last     = (r_clr == IW'(NUM_BLOCKS - 1));
        o_stat.empty        = (r_count == '0);
        o_stat.out_of_range = (r_addr < r_base) || (r_block_size == '0) ||
                              (MW'(w_off) >= MW'(r_span));
        o_stat.div_done     = w_div_done;
        o_stat.misaligned   = (w_rem != '0);
        o_stat.block_busy   = r_busy_q;
        o_stat.out_free     = !r_out_valid || i_out_ready;
    end

endmodule

// ===== hdl/fbpa_ctrl.sv =====
// Controller state machine of the block pool allocator: sequences one
// request at a time through the datapath. Uses fbpa_pkg.
module fbpa_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_kind,
    output logic                o_in_ready,
    input  fbpa_pkg::t_dp_stat  i_stat,
    output fbpa_pkg::t_dp_cmd   o_cmd
);

    fbpa_pkg::t_state r_state;
    fbpa_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fbpa_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fbpa_pkg::S_CLEAR: begin
                if (i_stat.clr_last) begin
                    n_state = fbpa_pkg::S_IDLE;
                end
            end
            fbpa_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_in_kind == fbpa_pkg::CMD_FREE) ? fbpa_pkg::S_F_RANGE
                                                                : fbpa_pkg::S_A_READ;
                end
            end
            fbpa_pkg::S_A_READ: begin
                n_state = i_stat.empty ? fbpa_pkg::S_DONE : fbpa_pkg::S_A_MUL;
            end
            fbpa_pkg::S_A_MUL:   n_state = fbpa_pkg::S_A_ADD;
            fbpa_pkg::S_A_ADD:   n_state = fbpa_pkg::S_DONE;
            fbpa_pkg::S_F_RANGE: begin
                n_state = i_stat.out_of_range ? fbpa_pkg::S_DONE : fbpa_pkg::S_F_DIV;
            end
            fbpa_pkg::S_F_DIV: begin
                if (i_stat.div_done) begin
                    n_state = i_stat.misaligned ? fbpa_pkg::S_DONE : fbpa_pkg::S_F_BUSY;
                end
            end
            fbpa_pkg::S_F_BUSY:  n_state = fbpa_pkg::S_DONE;
            fbpa_pkg::S_DONE: begin
                if (i_stat.out_free) begin
                    n_state = fbpa_pkg::S_IDLE;
                end
            end
            default: n_state = fbpa_pkg::S_CLEAR;
        endcase
        // a write of a listed register restarts the pool from scratch
        if (i_stat.reinit) begin
            n_state = fbpa_pkg::S_CLEAR;
        end
    end

    always_comb begin
        o_cmd         = '0;
        o_cmd.st_code = fbpa_pkg::ST_OK;
        o_in_ready    = 1'b0;
        unique case (r_state)
            fbpa_pkg::S_CLEAR: o_cmd.clr_step = 1'b1;
            fbpa_pkg::S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.take_in = i_in_valid;
            end
            fbpa_pkg::S_A_READ: begin
                if (i_stat.empty) begin
                    o_cmd.set_st  = 1'b1;
                    o_cmd.st_code = fbpa_pkg::ST_EMPTY;
                end else begin
                    o_cmd.pop = 1'b1;
                end
            end
            fbpa_pkg::S_A_MUL: o_cmd.mark     = 1'b1;
            fbpa_pkg::S_A_ADD: o_cmd.add_base = 1'b1;
            fbpa_pkg::S_F_RANGE: begin
                if (i_stat.out_of_range) begin
                    o_cmd.set_st  = 1'b1;
                    o_cmd.st_code = fbpa_pkg::ST_RANGE;
                end else begin
                    o_cmd.div_start = 1'b1;
                end
            end
            fbpa_pkg::S_F_DIV: begin
                if (i_stat.div_done) begin
                    if (i_stat.misaligned) begin
                        o_cmd.set_st  = 1'b1;
                        o_cmd.st_code = fbpa_pkg::ST_ALIGN;
                    end else begin
                        o_cmd.busy_rd = 1'b1;
                    end
                end
            end
            fbpa_pkg::S_F_BUSY: begin
                if (i_stat.block_busy) begin
                    o_cmd.push_free = 1'b1;
                end else begin
                    o_cmd.set_st  = 1'b1;
                    o_cmd.st_code = fbpa_pkg::ST_NOTALLOC;
                end
            end
            fbpa_pkg::S_DONE: o_cmd.load_out = i_stat.out_free;
            default: ;
        endcase
    end

endmodule

// ===== hdl/fixed_block_pool_allocator_core.sv =====
// Top level of the fixed-size block pool allocator.
// Instantiates fbpa_ctrl and fbpa_datapath; uses fbpa_pkg.
//
// Requests come in on the s_axis channel: tuser is the kind (0 allocate,
// 1 free) and tdata the address to free. Each request gives one result on
// the m_axis channel: the allocated block address and a status code.
// Blocks are handed out last-freed first; after init the highest index
// comes out first.
// An allocate pops the free stack, forms index * size and adds the base
// (an empty pool goes straight to the result); a free checks the range,
// then the restoring divider turns the offset into a block index and
// remainder and the busy bit is read (out of range or misaligned goes
// straight to the result). One request is in flight at a time; the next
// is taken the cycle after the result is loaded. Reset and any write of a
// listed register reinitialise the pool: a clearing pass sweeps the
// busy-bit memory, during which no request is taken. Registers are written
// by the user with no request outstanding; the block does not enforce this.
// If the receiver stalls, the result is held in the output register; one
// further request may be worked and then waits for the slot to empty.
module fixed_block_pool_allocator_core #(
    parameter int NUM_BLOCKS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    // requests
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [31:0] address
    input  logic        i_s_axis_tuser,   // [0] command
    // results
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata    // [31:0] block_address, [34:32] status
);

    fbpa_pkg::t_dp_cmd           w_cmd;
    fbpa_pkg::t_dp_stat          w_stat;
    logic [fbpa_pkg::ADDR_W-1:0] w_out_addr;
    fbpa_pkg::t_status           w_out_status;

    fbpa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_in_kind  (i_s_axis_tuser),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    fbpa_datapath #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_addr       (i_s_axis_tdata),
        .i_out_ready  (i_m_axis_tready),
        .o_out_valid  (o_m_axis_tvalid),
        .o_out_addr   (w_out_addr),
        .o_out_status (w_out_status),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat)
    );

    assign o_m_axis_tdata = {5'b0, w_out_status, w_out_addr};

endmodule

// ===== sim/fixed_block_pool_allocator_core_test.sv =====
// Self-checking bench for the fixed-size block pool allocator core.
// Directed table then randomised pool settings, each reply checked against the table's expected
// values or a behavioural model of the free stack and busy bits kept here. Needs fbpa_pkg and the core.
module fixed_block_pool_allocator_core_test;

    localparam int POOL_DEPTH      = 256;
    localparam int DRAIN_PAUSE     = 50;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int PRESSURE_AT     = 150;
    localparam int PRESSURE_CYCLES = 600;
    localparam int PHASES          = 8;
    localparam int PHASE_ITEMS     = 200;
    localparam int DIR_ROWS        = 31;

    // index past the register list: write is ignored, pool kept as is
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    typedef enum logic {ROW_REQ, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind         kind;
        logic [1:0]        reg_idx;
        logic              cmd;
        logic [31:0]       value;     // address to free, or register data
        bit                typed;
        logic [31:0]       exp_addr;
        fbpa_pkg::t_status exp_code;
    } t_stim_row;

    typedef struct {
        logic [31:0]       blk_addr;
        fbpa_pkg::t_status code;
    } t_pool_reply;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata;
    logic        i_s_axis_tuser;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [39:0] o_m_axis_tdata;

    // model of the pool
    logic [31:0] pool_base;
    logic [15:0] blk_size;
    logic [8:0]  pool_len;
    logic [7:0]  free_ids [POOL_DEPTH];
    bit          taken [POOL_DEPTH];
    int unsigned free_top;

    t_pool_reply due_replies [$];
    logic [31:0] held_blocks [$];
    int unsigned src_idle_pct;
    int unsigned sink_idle_pct;
    int unsigned mismatches = 0;
    int unsigned quiet_cycles = 0;

    fixed_block_pool_allocator_core #(
        .NUM_BLOCKS(POOL_DEPTH)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #10 i_clk = ~i_clk;

    function automatic int unsigned pool_depth_now();
        return (pool_len > POOL_DEPTH) ? POOL_DEPTH : int'(pool_len);
    endfunction

    function automatic void pool_reinit();
        for (int k = 0; k < POOL_DEPTH; k++) begin
            free_ids[k] = 8'(k);
            taken[k]    = 1'b0;
        end
        free_top = pool_depth_now();
    endfunction

    function automatic void apply_reg(input logic [1:0] idx, input logic [31:0] data);
        unique case (idx)
            fbpa_pkg::CFG_BASE: pool_base = data;
            fbpa_pkg::CFG_BS:   blk_size  = data[15:0];
            fbpa_pkg::CFG_POOL: pool_len  = data[8:0];
            default:            return;
        endcase
        pool_reinit();
    endfunction

    function automatic void compute_pool_reply(input logic cmd, input logic [31:0] addr,
                                               output logic [31:0] blk,
                                               output fbpa_pkg::t_status code);
        logic [63:0] pool_end;
        logic [31:0] off;
        int unsigned idx;
        blk  = 32'd0;
        code = fbpa_pkg::ST_OK;
        if (cmd == fbpa_pkg::CMD_ALLOC) begin
            if (free_top == 0) begin
                code = fbpa_pkg::ST_EMPTY;
            end else begin
                free_top--;
                idx = free_ids[free_top];
                taken[idx] = 1'b1;
                blk = pool_base + idx * blk_size;
            end
        end else begin
            // pool end worked out without wrap
            pool_end = 64'(pool_base) + 64'(pool_depth_now()) * 64'(blk_size);
            if (addr < pool_base || 64'(addr) >= pool_end || blk_size == 16'd0) begin
                code = fbpa_pkg::ST_RANGE;
            end else begin
                off = addr - pool_base;
                if (off % blk_size != 0) begin
                    code = fbpa_pkg::ST_ALIGN;
                end else begin
                    idx = off / blk_size;
                    if (!taken[idx]) begin
                        code = fbpa_pkg::ST_NOTALLOC;
                    end else begin
                        taken[idx] = 1'b0;
                        if (free_top < POOL_DEPTH) begin
                            free_ids[free_top] = 8'(idx);
                            free_top++;
                        end
                    end
                end
            end
        end
    endfunction

    task automatic send_request(input logic cmd, input logic [31:0] addr);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= cmd;
        i_s_axis_tdata  <= addr;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
    endtask

    // stop offering, wait for every reply, then a short quiet gap
    task automatic settle_idle();
        i_s_axis_tvalid <= 1'b0;
        while (due_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_PAUSE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        apply_reg(idx, data);
        if (idx != CFG_UNUSED) held_blocks.delete();
    endtask

    // replies side: checks and the ready pattern, including one long hold-off
    initial begin : reply_sink
        t_pool_reply want;
        int unsigned results_seen;
        int unsigned hold_left;
        results_seen = 0;
        hold_left    = 0;
        i_m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
                results_seen++;
                if (due_replies.size() == 0) begin
                    $error("reply with no request outstanding: tdata %h", o_m_axis_tdata);
                    mismatches++;
                end else begin
                    want = due_replies.pop_front();
                    if (o_m_axis_tdata[31:0] !== want.blk_addr) begin
                        $error("block_address: expected %h, got %h",
                               want.blk_addr, o_m_axis_tdata[31:0]);
                        mismatches++;
                    end
                    if (o_m_axis_tdata[34:32] !== want.code) begin
                        $error("status: expected %0d, got %0d",
                               want.code, o_m_axis_tdata[34:32]);
                        mismatches++;
                    end
                end
                if (results_seen == PRESSURE_AT) hold_left = PRESSURE_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_s_axis_tvalid && o_s_axis_tready)
                || (o_m_axis_tvalid && i_m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == WATCHDOG_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin : stimulus
        t_stim_row         directed_rows [DIR_ROWS];
        t_stim_row         row;
        logic              cmd;
        logic [31:0]       addr;
        logic [31:0]       blk;
        logic [31:0]       base_v;
        logic [15:0]       bs_v;
        logic [8:0]        pool_v;
        fbpa_pkg::t_status code;
        int unsigned       r;
        int unsigned       pick;
        int unsigned       alloc_pct;

        directed_rows = '{
            // defaults: base 0, 64-byte blocks, 256 blocks
            '{ROW_REQ, fbpa_pkg::CFG_BASE, fbpa_pkg::CMD_ALLOC, 32'h0,
              1'b1, 32'h3FC0, fbpa_pkg::ST_OK},
            '{ROW_REQ, fbpa_pkg::CFG_BASE, fbpa_pkg::CMD_ALLOC, 32'h0,
              1'b1, 32'h3F80, fbpa_pkg::ST_OK},
            '{ROW_REQ, fbpa_pkg::CFG_BASE, fbpa_pkg::CMD_FREE, 32'h3FC0,
              1'b1, 32'h0, fbpa_pkg::ST_OK},
            '{ROW_REQ, fbpa_pkg::CFG_BASE, fbpa_pkg::CMD_FREE, 32'h3FC0,
              1'b1, 32'h0, fbpa_pkg::ST_NOTALLOC},
            '{ROW_REQ, fbpa_pkg::CFG_BASE, fbpa_pkg::CMD_FREE, 32'h3FC1,
              1'b1, 32'h0, fbpa_pkg::ST_ALIGN},
            '{ROW_REQ, fbpa_pkg::CFG_BASE, fbpa_pkg::CMD_FREE, 32'h4000,
              1'b1, 32'h0, fbpa_pkg::ST_RANGE},
            '{ROW_REQ, fbpa_pkg::CFG_BASE, fbpa_pkg::CMD_FREE, 32'hFFFF_FFFF,
              1'b1, 32'h0, fbpa_pkg::ST_RANGE},
            '{ROW_REQ, fbpa_pkg::CFG_BASE, fbpa_pkg::CMD_FREE, 32'h0,
              1'b1, 32'h0, fbpa_pkg::ST_NOTALLOC},
            '{ROW_REQ, fbpa_pkg::CFG_BASE, fbpa_pkg::CMD_ALLOC, 32'hFFFF_FFFF,
              1'b1, 32'h3FC0, fbpa_pkg::ST_OK},
            // empty pool
            '{ROW_CFG, fbpa_pkg::CFG_POOL, fbpa_pkg::CMD_ALLOC, 32'd0,
              1'b0, 32'h0, fbpa_pkg::ST_OK},
            '{ROW_REQ, fbpa_pkg::CFG_BASE, fbpa_pkg::CMD_ALLOC, 32'h0,
              1'b1, 32'h0, fbpa_pkg::ST_EMPTY},
            '{ROW_REQ, fbpa_pkg::CFG_BASE, fbpa_pkg::CMD_FREE, 32'h0,
              1'b1, 32'h0, fbpa_pkg::ST_RANGE},
            // two blocks: run dry, hand one back
            '{ROW_CFG, fbpa_pkg::CFG_POOL, fbpa_pkg::CMD_ALLOC, 32'd2,
              1'b0, 32'h0, fbpa_pkg::ST_OK},
            '{ROW_REQ, fbpa_pkg::CFG_BASE, fbpa_pkg::CMD_ALLOC, 32'h0,
              1'b1, 32'd64, fbpa_pkg::ST_OK},
            '{ROW_REQ, fbpa_pkg::CFG_BASE, fbpa_pkg::CMD_ALLOC, 32'h0,
              1'b1, 32'h0, fbpa_pkg::ST_OK},
            '{ROW_REQ, fbpa_pkg::CFG_BASE, fbpa_pkg::CMD_ALLOC, 32'h0,
              1'b1, 32'h0, fbpa_pkg::ST_EMPTY},
            '{ROW_REQ, fbpa_pkg::CFG_BASE, fbpa_pkg::CMD_FREE, 32'd64,
              1'b1, 32'h0, fbpa_pkg::ST_OK},
            // zero block size
            '{ROW_CFG, fbpa_pkg::CFG_BS, fbpa_pkg::CMD_ALLOC, 32'd0,
              1'b0, 32'h0, fbpa_pkg::ST_OK},
            '{ROW_REQ, fbpa_pkg::CFG_BASE, fbpa_pkg::CMD_ALLOC, 32'h0,
              1'b1, 32'h0, fbpa_pkg::ST_OK},
            '{ROW_REQ, fbpa_pkg::CFG_BASE, fbpa_pkg::CMD_FREE, 32'h0,
              1'b1, 32'h0, fbpa_pkg::ST_RANGE},
            // unlisted register: no reinit, so block 0 is still free
            '{ROW_CFG, CFG_UNUSED, fbpa_pkg::CMD_ALLOC, 32'h0001_2345,
              1'b0, 32'h0, fbpa_pkg::ST_OK},
            '{ROW_REQ, fbpa_pkg::CFG_BASE, fbpa_pkg::CMD_ALLOC, 32'h0,
              1'b1, 32'h0, fbpa_pkg::ST_OK},
            '{ROW_REQ, fbpa_pkg::CFG_BASE, fbpa_pkg::CMD_ALLOC, 32'h0,
              1'b1, 32'h0, fbpa_pkg::ST_EMPTY},
            // pool past the top of the address space, size saturated to depth
            '{ROW_CFG, fbpa_pkg::CFG_BASE, fbpa_pkg::CMD_ALLOC, 32'hFFFF_FFF0,
              1'b0, 32'h0, fbpa_pkg::ST_OK},
            '{ROW_CFG, fbpa_pkg::CFG_BS, fbpa_pkg::CMD_ALLOC, 32'h0000_FFFF,
              1'b0, 32'h0, fbpa_pkg::ST_OK},
            '{ROW_CFG, fbpa_pkg::CFG_POOL, fbpa_pkg::CMD_ALLOC, 32'h0000_01FF,
              1'b0, 32'h0, fbpa_pkg::ST_OK},
            '{ROW_REQ, fbpa_pkg::CFG_BASE, fbpa_pkg::CMD_ALLOC, 32'h0,
              1'b0, 32'h0, fbpa_pkg::ST_OK},
            '{ROW_REQ, fbpa_pkg::CFG_BASE, fbpa_pkg::CMD_FREE, 32'h00FF_00F1,
              1'b0, 32'h0, fbpa_pkg::ST_OK},
            '{ROW_REQ, fbpa_pkg::CFG_BASE, fbpa_pkg::CMD_FREE, 32'hFFFF_FFF0,
              1'b0, 32'h0, fbpa_pkg::ST_OK},
            '{ROW_REQ, fbpa_pkg::CFG_BASE, fbpa_pkg::CMD_FREE, 32'hFFFF_FFFF,
              1'b0, 32'h0, fbpa_pkg::ST_OK},
            '{ROW_REQ, fbpa_pkg::CFG_BASE, fbpa_pkg::CMD_ALLOC, 32'h0,
              1'b0, 32'h0, fbpa_pkg::ST_OK}
        };

        src_idle_pct  = 24;
        sink_idle_pct = 58;
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_index     <= fbpa_pkg::CFG_BASE;
        i_cfg_data      <= 32'd0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= 32'd0;
        i_s_axis_tuser  <= fbpa_pkg::CMD_ALLOC;
        pool_base = fbpa_pkg::RST_BASE;
        blk_size  = fbpa_pkg::RST_BS;
        pool_len  = fbpa_pkg::RST_POOL;
        pool_reinit();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.kind == ROW_CFG) begin
                settle_idle();
                write_reg(row.reg_idx, row.value);
            end else begin
                compute_pool_reply(row.cmd, row.value, blk, code);
                if (row.typed) due_replies.push_back(t_pool_reply'{row.exp_addr, row.exp_code});
                else due_replies.push_back(t_pool_reply'{blk, code});
                send_request(row.cmd, row.value);
            end
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            settle_idle();
            unique case (phase)
                0: begin base_v = $urandom(); bs_v = 16'd1; pool_v = 9'd8; end
                1: begin
                    base_v = $urandom();
                    bs_v   = 16'($urandom_range(1, 64));
                    pool_v = 9'($urandom_range(1, 16));
                end
                2: begin base_v = 32'hFFFF_FFFF; bs_v = 16'hFFFF; pool_v = 9'h1FF; end
                3: begin base_v = 32'd0; bs_v = 16'($urandom_range(1, 65535)); pool_v = 9'd256; end
                4: begin base_v = $urandom(); bs_v = 16'd0; pool_v = 9'($urandom_range(1, 16)); end
                5: begin base_v = $urandom(); bs_v = 16'($urandom_range(1, 65535)); pool_v = 9'd0; end
                6: begin
                    base_v = $urandom();
                    bs_v   = 16'($urandom_range(1, 300));
                    pool_v = 9'($urandom_range(1, 511));
                end
                default: begin
                    base_v = $urandom();
                    bs_v   = 16'($urandom_range(1, 65535));
                    pool_v = 9'($urandom_range(1, 32));
                end
            endcase
            if (phase == 3) write_reg(CFG_UNUSED, $urandom());
            write_reg(fbpa_pkg::CFG_BASE, base_v);
            // later phases put junk above the register width
            if (phase >= 6) begin
                write_reg(fbpa_pkg::CFG_BS, {16'($urandom()), bs_v});
                write_reg(fbpa_pkg::CFG_POOL, {23'($urandom()), pool_v});
            end else begin
                write_reg(fbpa_pkg::CFG_BS, {16'd0, bs_v});
                write_reg(fbpa_pkg::CFG_POOL, {23'd0, pool_v});
            end

            if (phase < 3) begin
                src_idle_pct  = 24;
                sink_idle_pct = 58;
            end else if (phase < 6) begin
                src_idle_pct  = 58;
                sink_idle_pct = 24;
            end else begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            alloc_pct = (phase == 3) ? 85 : 45;

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 99) < alloc_pct) begin
                    cmd  = fbpa_pkg::CMD_ALLOC;
                    addr = $urandom();
                end else begin
                    cmd = fbpa_pkg::CMD_FREE;
                    r   = $urandom_range(0, 99);
                    if (r < 60 && held_blocks.size() != 0) begin
                        pick = $urandom_range(0, held_blocks.size() - 1);
                        addr = held_blocks[pick];
                        held_blocks.delete(pick);
                    end else if (r < 85) begin
                        // near a block boundary, possibly one past the end
                        addr = pool_base + $urandom_range(0, pool_depth_now()) * blk_size;
                        if (blk_size > 16'd1 && $urandom_range(0, 1) == 1)
                            addr = addr + $urandom_range(1, blk_size - 1);
                    end else if (r < 90) begin
                        addr = pool_base - 32'd1;
                    end else begin
                        addr = $urandom();
                    end
                end
                compute_pool_reply(cmd, addr, blk, code);
                due_replies.push_back(t_pool_reply'{blk, code});
                if (cmd == fbpa_pkg::CMD_ALLOC && code == fbpa_pkg::ST_OK)
                    held_blocks.push_back(blk);
                send_request(cmd, addr);
            end
        end

        settle_idle();
        if (mismatches == 0 && due_replies.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
